[hw/rtl/fqmm_pkg.sv]
package fqmm_pkg;

  // Default number of entries held by the queue.
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;

  // Command codes.
  localparam logic [ACTION_W-1:0] ACT_PUSH  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LIST  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_MAX   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_MIN   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_FIND  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_NOP   = 3'd7;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] result_value;
    logic [POS_W-1:0]          position;
    logic                      last;
  } out_item_t;

endpackage

[hw/rtl/fifo_queue_with_min_max_search.sv]
// Channel  | Ports                         | Handshake
// ---------+-------------------------------+--------------------------------------
// input    | start, busy, in_item          | item taken at an edge with start && !busy
// result   | out_valid, out_item           | each item presented once, no backpressure
//
// Push, clear, nop and any command on an empty queue leave busy low, and the result, if
// any (nop gives none), follows the next edge. Pop, list, max, min and find pass
// through SCAN and WAIT (max, min and find also through FIN), reading the entries
// through the single read port of the entry memory (one entry per cycle).
// Reset is synchronous and active low; it empties the queue by clearing the count, no sweep.
// The receiver cannot stall, so every result is presented exactly once.
module fifo_queue_with_min_max_search #(
  parameter int QUEUE_DEPTH = fqmm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fqmm_pkg::in_item_t in_item,
  output logic               out_valid,
  output fqmm_pkg::out_item_t out_item
);

  import fqmm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  // The sequencer walks the memory: SCAN issues one read per cycle, WAIT takes the
  // last read data, and FIN sends the single closing item of a max, min or find.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_FIN
  } state_t;

  state_t                state_r;
  logic [PW-1:0]         head_r;
  logic [CW-1:0]         cnt_r;
  logic [ACTION_W-1:0]   act_r;
  logic signed [VALUE_W-1:0] opnd_r;
  logic [PW-1:0]         rd_idx_r;
  logic [PW-1:0]         scan_end_r;
  logic                  dv_r;
  logic [PW-1:0]         dv_idx_r;
  logic signed [VALUE_W-1:0] best_r;
  logic                  found_r;
  logic [POS_W-1:0]      pend_pos_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [PW-1:0]         rd_addr;
  logic                  rd_en;
  logic [VALUE_W-1:0]    rd_data;
  logic signed [VALUE_W-1:0] dv_data;
  logic                  dv_last;
  logic [CW-1:0]         dv_pos_full;
  logic [POS_W-1:0]      dv_pos;

  // Ring addressing: both operands are below the depth, so one conditional
  // subtract brings the sum back into range.
  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] base,
                                         input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[PW-1:0];
  endfunction

  function automatic out_item_t mk_out(input logic [STATUS_W-1:0] st,
                                       input logic signed [VALUE_W-1:0] val,
                                       input logic [POS_W-1:0] pos,
                                       input logic lst);
    out_item_t o;
    o.status       = st;
    o.result_value = val;
    o.position     = pos;
    o.last         = lst;
    return o;
  endfunction

  assign accept  = start && (state_r == S_IDLE);
  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);

  // A push writes at the tail. Reads only occur in later cycles, and no push can be
  // taken while a scan runs, so read and write never race for an entry.
  assign wr_en   = accept && (in_item.action == ACT_PUSH) && !full;
  assign wr_addr = wrap(head_r, cnt_r[PW-1:0]);
  assign rd_en   = (state_r == S_SCAN);
  assign rd_addr = wrap(head_r, rd_idx_r);

  fqmm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_item.operand_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign dv_data     = $signed(rd_data);
  assign dv_last     = (dv_idx_r == scan_end_r);
  assign dv_pos_full = CW'(dv_idx_r) + CW'(1);
  assign dv_pos      = POS_W'(dv_pos_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      dv_r        <= rd_en;
      dv_idx_r    <= rd_idx_r;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            act_r      <= in_item.action;
            opnd_r     <= in_item.operand_value;
            rd_idx_r   <= '0;
            found_r    <= 1'b0;
            scan_end_r <= (in_item.action == ACT_POP) ? '0 : PW'(cnt_r - CW'(1));
            unique case (in_item.action)
              ACT_PUSH: begin
                out_valid_r <= 1'b1;
                out_r <= mk_out(full ? ST_FULL : ST_OK, in_item.operand_value, '0, 1'b1);
                if (!full) begin
                  cnt_r <= cnt_r + CW'(1);
                end
              end
              ACT_CLEAR: begin
                head_r      <= '0;
                cnt_r       <= '0;
                out_valid_r <= 1'b1;
                out_r       <= mk_out(ST_OK, '0, '0, 1'b1);
              end
              ACT_NOP: begin
              end
              default: begin
                if (empty) begin
                  out_valid_r <= 1'b1;
                  out_r       <= mk_out(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                  state_r <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_idx_r <= rd_idx_r + PW'(1);
          if (rd_idx_r == scan_end_r) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          // The last read data is handled below in this same cycle.
          if (act_r == ACT_MAX || act_r == ACT_MIN || act_r == ACT_FIND) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_FIN: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          if (act_r == ACT_FIND) begin
            out_r <= found_r ? mk_out(ST_OK, opnd_r, pend_pos_r, 1'b1)
                             : mk_out(ST_NOT_FOUND, opnd_r, '0, 1'b1);
          end else begin
            out_r <= mk_out(ST_OK, best_r, '0, 1'b1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Read data returns in the cycle after its address; it never lands in IDLE or FIN.
      if (dv_r) begin
        case (act_r)
          ACT_POP: begin
            out_valid_r <= 1'b1;
            out_r       <= mk_out(ST_OK, dv_data, '0, 1'b1);
            head_r      <= wrap(head_r, PW'(1));
            cnt_r       <= cnt_r - CW'(1);
          end
          ACT_LIST: begin
            out_valid_r <= 1'b1;
            out_r       <= mk_out(ST_OK, dv_data, dv_pos, dv_last);
          end
          ACT_MAX: begin
            if (dv_idx_r == '0 || dv_data > best_r) begin
              best_r <= dv_data;
            end
          end
          ACT_MIN: begin
            if (dv_idx_r == '0 || dv_data < best_r) begin
              best_r <= dv_data;
            end
          end
          ACT_FIND: begin
            // A match is held back one step so that the final one can carry last.
            if (dv_data == opnd_r) begin
              if (found_r) begin
                out_valid_r <= 1'b1;
                out_r       <= mk_out(ST_OK, opnd_r, pend_pos_r, 1'b0);
              end
              found_r    <= 1'b1;
              pend_pos_r <= dv_pos;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count above queue depth");

  a_no_data_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !dv_r)
    else $error("read data returned outside a scan");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.action == ACT_CLEAR) |=>
      (out_valid && cnt_r == '0 && out_item.status == ST_OK && out_item.last))
    else $error("clear did not empty the queue");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r <= scan_end_r && !empty))
    else $error("scan index past the stored entries");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r && act_r == ACT_POP) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("pop did not remove one entry");

endmodule

[hw/rtl/fqmm_ram.sv]
module fqmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
